FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the 4x4 matrix multiply unit.
// Needs a clock named clock and a synchronous active-high reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define MM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Property that must hold in the cycle after its trigger.
`define MM_ASSERT_NEXT(lbl, trig, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) else $error(msg);

`endif

FILE: hw/rtl/mm4_pkg.sv
// Shared types and constants of the 4x4 matrix multiply unit.
// No dependencies.
package mm4_pkg;

   // matrix size and field widths
   localparam int DIM    = 4;
   localparam int IDX_W  = 2;
   localparam int VAL_W  = 32;
   localparam int FRAC_W = 16;
   localparam int PROD_W = 2 * VAL_W;
   localparam int SUM_W  = PROD_W + $clog2(DIM);
   localparam int SH_W   = SUM_W - FRAC_W;
   localparam int CNT_W  = 2 * IDX_W;

   // request action codes
   localparam logic [1:0] ACT_LOAD_A  = 2'd0;
   localparam logic [1:0] ACT_LOAD_B  = 2'd1;
   localparam logic [1:0] ACT_COMPUTE = 2'd2;

   // element write broadcast to all cells
   typedef struct packed {
      logic               ld_a;
      logic               ld_b;
      logic [IDX_W-1:0]   row;
      logic [IDX_W-1:0]   col;
      logic [VAL_W-1:0]   value;
   } load_type;

   // partial sum token passed from cell to cell
   typedef struct packed {
      logic                    vld;
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [SUM_W-1:0] sum;
   } tok_type;

endpackage

FILE: hw/rtl/matrix_4x4_multiply_unit.sv
// Load requests write one element of A or B and are taken one per cycle
// while no compute is in progress. A compute request holds req_stall high
// until its sixteen product entries, row-major, have all been taken; entries
// come out one per cycle unless rsp_stall holds them back, and the next
// request is taken only after the last entry has been taken.
// Each entry passes through the chain of four cells, each a multiply stage
// and an accumulate stage, then the saturating response register.
// Top level; uses mm4_pkg, mm4_cell, mm4_sat and assert_macros.svh.
module matrix_4x4_multiply_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_action,
   input  logic [mm4_pkg::IDX_W-1:0]         req_row,
   input  logic [mm4_pkg::IDX_W-1:0]         req_col,
   input  logic signed [mm4_pkg::VAL_W-1:0]  req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [mm4_pkg::IDX_W-1:0]         rsp_out_row,
   output logic [mm4_pkg::IDX_W-1:0]         rsp_out_col,
   output logic signed [mm4_pkg::VAL_W-1:0]  rsp_product_value,
   output logic                             rsp_saturated,
   output logic                             rsp_last
);

`include "assert_macros.svh"

   logic                       req_take;
   logic                       start;
   logic                       done;
   logic                       adv;
   logic                       busy_ff;
   logic                       busy_in;
   logic                       issue_ff;
   logic                       issue_in;
   logic [mm4_pkg::CNT_W-1:0]  cnt_ff;
   logic [mm4_pkg::CNT_W-1:0]  cnt_in;
   mm4_pkg::load_type          ld;
   mm4_pkg::tok_type           chain [mm4_pkg::DIM+1];

   assign req_stall = busy_ff;
   assign req_take  = req_valid && !req_stall;

   // decode the request
   always_comb begin
      ld       = '0;
      ld.row   = req_row;
      ld.col   = req_col;
      ld.value = req_value;
      start    = 1'b0;
      case (req_action)
         mm4_pkg::ACT_LOAD_A:  ld.ld_a = req_take;
         mm4_pkg::ACT_LOAD_B:  ld.ld_b = req_take;
         mm4_pkg::ACT_COMPUTE: start   = req_take;
         default:              start   = 1'b0;
      endcase
   end

   assign done = rsp_valid && !rsp_stall && rsp_last;

   // sequencer: issues entry indices into the chain
   always_comb begin
      busy_in  = busy_ff;
      issue_in = issue_ff;
      cnt_in   = cnt_ff;
      if (start) begin
         busy_in  = 1'b1;
         issue_in = 1'b1;
         cnt_in   = '0;
      end else begin
         if (issue_ff && adv) begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == mm4_pkg::CNT_W'(mm4_pkg::DIM * mm4_pkg::DIM - 1)) begin
               issue_in = 1'b0;
            end
         end
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         issue_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         issue_ff <= issue_in;
         cnt_ff   <= cnt_in;
      end
   end

   // token entering the first cell
   assign chain[0].vld = issue_ff;
   assign chain[0].row = cnt_ff[mm4_pkg::CNT_W-1:mm4_pkg::IDX_W];
   assign chain[0].col = cnt_ff[mm4_pkg::IDX_W-1:0];
   assign chain[0].sum = '0;

   // chain of cells, one per inner index k
   for (genvar k = 0; k < mm4_pkg::DIM; k++) begin : g_cell
      mm4_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (mm4_pkg::IDX_W'(k)),
         .adv      (adv),
         .ld       (ld),
         .tok_in   (chain[k]),
         .tok_out  (chain[k+1])
      );
   end

   mm4_sat u_sat (
      .clock             (clock),
      .reset             (reset),
      .tok_in            (chain[mm4_pkg::DIM]),
      .adv               (adv),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_product_value (rsp_product_value),
      .rsp_saturated     (rsp_saturated),
      .rsp_last          (rsp_last)
   );

   // checks
   `MM_ASSERT(a_idle_no_rsp, !busy_ff |-> !rsp_valid, "response while unit idle")
   `MM_ASSERT(a_issue_busy, issue_ff |-> busy_ff, "issuing entries while not busy")
   `MM_ASSERT_NEXT(a_start_busy, start, busy_ff && issue_ff && cnt_ff == '0, "compute did not start")
   `MM_ASSERT(a_last_done, (rsp_valid && rsp_last) |-> !issue_ff, "last entry before issue ended")

endmodule

FILE: hw/rtl/mm4_cell.sv
// One cell of the product chain: holds column k of A and row k of B,
// adds A[i][k]*B[k][j] to the passing partial sum. Uses mm4_pkg.
module mm4_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [mm4_pkg::IDX_W-1:0] cell_idx,
   input  logic                     adv,
   input  mm4_pkg::load_type        ld,
   input  mm4_pkg::tok_type         tok_in,
   output mm4_pkg::tok_type         tok_out
);

   logic [mm4_pkg::VAL_W-1:0]        a_col_ff [mm4_pkg::DIM];
   logic [mm4_pkg::VAL_W-1:0]        b_row_ff [mm4_pkg::DIM];
   logic signed [mm4_pkg::PROD_W-1:0] prod_in;
   logic signed [mm4_pkg::PROD_W-1:0] prod_ff;
   mm4_pkg::tok_type                 s1_ff;
   mm4_pkg::tok_type                 s2_in;
   mm4_pkg::tok_type                 s2_ff;

   // element stores, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < mm4_pkg::DIM; n++) begin
            a_col_ff[n] <= '0;
            b_row_ff[n] <= '0;
         end
      end else begin
         if (ld.ld_a && ld.col == cell_idx) begin
            a_col_ff[ld.row] <= ld.value;
         end
         if (ld.ld_b && ld.row == cell_idx) begin
            b_row_ff[ld.col] <= ld.value;
         end
      end
   end

   // stage 1: product of the selected pair
   assign prod_in = $signed(a_col_ff[tok_in.row]) * $signed(b_row_ff[tok_in.col]);

   // stage 2: accumulate into the partial sum
   always_comb begin
      s2_in     = s1_ff;
      s2_in.sum = s1_ff.sum + mm4_pkg::SUM_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld <= 1'b0;
         s2_ff.vld <= 1'b0;
      end else if (adv) begin
         s1_ff   <= tok_in;
         prod_ff <= prod_in;
         s2_ff   <= s2_in;
      end
   end

   assign tok_out = s2_ff;

endmodule

FILE: hw/rtl/mm4_sat.sv
// Output stage: scales the chain's sum back to Q16.16, saturates and
// holds the response register. Uses mm4_pkg.
module mm4_sat (
   input  logic                             clock,
   input  logic                             reset,
   input  mm4_pkg::tok_type                 tok_in,
   output logic                             adv,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [mm4_pkg::IDX_W-1:0]         rsp_out_row,
   output logic [mm4_pkg::IDX_W-1:0]         rsp_out_col,
   output logic signed [mm4_pkg::VAL_W-1:0]  rsp_product_value,
   output logic                             rsp_saturated,
   output logic                             rsp_last
);

   localparam logic [mm4_pkg::VAL_W-1:0] MAX_VAL = {1'b0, {(mm4_pkg::VAL_W-1){1'b1}}};
   localparam logic [mm4_pkg::VAL_W-1:0] MIN_VAL = {1'b1, {(mm4_pkg::VAL_W-1){1'b0}}};

   logic [mm4_pkg::SH_W-1:0]               shifted;
   logic [mm4_pkg::SH_W-mm4_pkg::VAL_W:0]  top_bits;
   logic                                  sat_in;
   logic [mm4_pkg::VAL_W-1:0]              val_in;
   logic                                  last_in;
   logic                                  valid_ff;
   logic [mm4_pkg::IDX_W-1:0]              row_ff;
   logic [mm4_pkg::IDX_W-1:0]              col_ff;
   logic [mm4_pkg::VAL_W-1:0]              val_ff;
   logic                                  sat_ff;
   logic                                  last_ff;

   // whole chain moves unless a response is held back
   assign adv = !(valid_ff && rsp_stall);

   // floor shift, then clip to the 32-bit signed range
   assign shifted  = tok_in.sum[mm4_pkg::SUM_W-1:mm4_pkg::FRAC_W];
   assign top_bits = shifted[mm4_pkg::SH_W-1:mm4_pkg::VAL_W-1];
   assign sat_in   = !((&top_bits) || !(|top_bits));
   assign val_in   = sat_in ? (shifted[mm4_pkg::SH_W-1] ? MIN_VAL : MAX_VAL)
                            : shifted[mm4_pkg::VAL_W-1:0];
   assign last_in  = (tok_in.row == mm4_pkg::IDX_W'(mm4_pkg::DIM - 1)) &&
                     (tok_in.col == mm4_pkg::IDX_W'(mm4_pkg::DIM - 1));

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= tok_in.vld;
         row_ff   <= tok_in.row;
         col_ff   <= tok_in.col;
         val_ff   <= val_in;
         sat_ff   <= sat_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_row       = row_ff;
   assign rsp_out_col       = col_ff;
   assign rsp_product_value = val_ff;
   assign rsp_saturated     = sat_ff;
   assign rsp_last          = last_ff;

endmodule
